// ----- rtl/core/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map engine: transaction
// structs, operation and status codes, fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

   localparam int KEY_W     = 64;
   localparam int VALUE_W   = 16;
   localparam int KEY_BYTES = KEY_W / 8;
   localparam int BYTE_IDX_W = $clog2(KEY_BYTES);
   // byte sum of a full key fits here
   localparam int SUM_W     = $clog2(KEY_BYTES * 255 + 1);

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_SCAN   = 2'd3;

   // result status codes
   localparam logic [2:0] ST_ADDED      = 3'd0;
   localparam logic [2:0] ST_UPDATED    = 3'd1;
   localparam logic [2:0] ST_CHAIN_FULL = 3'd2;
   localparam logic [2:0] ST_REMOVED    = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
   localparam logic [2:0] ST_FOUND      = 3'd5;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [KEY_W-1:0]          item_key;
      logic signed [VALUE_W-1:0] item_value;
      logic signed [VALUE_W-1:0] range_low;
      logic signed [VALUE_W-1:0] range_high;
   } req_item_type;

   typedef struct packed {
      logic [2:0]                status;
      logic [KEY_W-1:0]          found_key;
      logic signed [VALUE_W-1:0] found_value;
      logic                      last_result;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- rtl/core/chm_hash.sv -----
// ----------------------------------------------------------------------------
// chm_hash
// Key trim and bucket hash: one key byte per cycle into a running sum, then
// a reciprocal multiply and a subtract for the sum modulo the bucket count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chm_hash import chm_pkg::*; #(
   parameter int BUCKETS   = 11,
   parameter int KEY_CHARS = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [KEY_W-1:0]           raw_key,
   output logic                            done,
   output logic [KEY_W-1:0]                key_out,
   output logic [$clog2(BUCKETS)-1:0]      bucket_out
);

   localparam int BW          = $clog2(BUCKETS);
   localparam int RECIP_SHIFT = 18;
   // rounded-up reciprocal, exact quotient for every byte sum
   localparam int RECIP       = (2**RECIP_SHIFT + BUCKETS - 1) / BUCKETS;
   localparam int PROD_W      = SUM_W + RECIP_SHIFT;

   typedef enum logic [1:0] {H_IDLE, H_SUM, H_MUL, H_MOD} state_type;

   state_type              state_ff, state_in;
   logic                   done_ff, done_in;
   logic [KEY_W-1:0]       raw_ff, raw_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [BYTE_IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic                   ended_ff, ended_in;
   logic [SUM_W-1:0]       quot_ff, quot_in;
   logic [BW-1:0]          rem_ff, rem_in;

   logic [7:0]             cur_byte;
   logic                   keep_byte;
   logic [PROD_W-1:0]      recip_prod;
   logic [SUM_W-1:0]       quot_times_b;

   assign cur_byte  = raw_ff[{byte_idx_ff, 3'b000} +: 8];
   assign keep_byte = !ended_ff && (cur_byte != 8'd0) &&
                      ((BYTE_IDX_W + 1)'(byte_idx_ff) < (BYTE_IDX_W + 1)'(KEY_CHARS));
   assign recip_prod   = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign quot_times_b = quot_ff * SUM_W'(BUCKETS);

   always_comb begin
      state_in    = state_ff;
      done_in     = 1'b0;
      raw_in      = raw_ff;
      key_in      = key_ff;
      sum_in      = sum_ff;
      byte_idx_in = byte_idx_ff;
      ended_in    = ended_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               raw_in      = raw_key;
               key_in      = '0;
               sum_in      = '0;
               byte_idx_in = '0;
               ended_in    = 1'b0;
               state_in    = H_SUM;
            end
         end
         H_SUM: begin
            // the key stops at its first zero byte or after KEY_CHARS bytes
            if (keep_byte) begin
               key_in[{byte_idx_ff, 3'b000} +: 8] = cur_byte;
               sum_in = sum_ff + SUM_W'(cur_byte);
            end else begin
               ended_in = 1'b1;
            end
            byte_idx_in = byte_idx_ff + BYTE_IDX_W'(1);
            if (byte_idx_ff == BYTE_IDX_W'(KEY_BYTES - 1)) begin
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            // quotient of the sum by the bucket count
            quot_in  = recip_prod[PROD_W-1:RECIP_SHIFT];
            state_in = H_MOD;
         end
         H_MOD: begin
            rem_in   = BW'(sum_ff - quot_times_b);
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      raw_ff      <= raw_in;
      key_ff      <= key_in;
      sum_ff      <= sum_in;
      byte_idx_ff <= byte_idx_in;
      ended_ff    <= ended_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
   end

   assign done       = done_ff;
   assign key_out    = key_ff;
   assign bucket_out = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/core/chained_hash_map_engine.sv -----
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key-value store with separate chaining: insert, remove, lookup by key and
// value range scan over a slot memory driven by a small sequencer.
// ----------------------------------------------------------------------------
//
//   channel   ports                  direction   handshake
//   -------   --------------------   ---------   -------------------------------
//   request   start, busy, req_item  in          taken when start & !busy
//   response  rsp_strobe, rsp_item   out         one-cycle strobe, never stalled
//
// key operations: hashing (one byte per cycle, then a reciprocal multiply and a
//   subtract for the modulo), a read and a compare per chain entry through the
//   registered memory read port, a further read state when the key is missing,
//   then the update; remove adds a read and a write per entry moved up, plus a read
// range scan: one slot read per cycle over occupied slots, a step to the next
//   bucket after each chain and a closing state that sends the last result
// busy stays high for the whole transaction and drops as the final result is
//   strobed; results are strobed for one cycle each and the receiver cannot stall them
// synchronous reset empties every chain; slot contents are never cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_map_engine import chm_pkg::*; #(
   parameter int BUCKETS     = 11,
   parameter int CHAIN_DEPTH = 4,
   parameter int KEY_CHARS   = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire req_item_type  req_item,
   output logic               rsp_strobe,
   output rsp_item_type       rsp_item
);

   localparam int BW     = $clog2(BUCKETS);
   localparam int SLOTS  = BUCKETS * CHAIN_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HASH,
      S_FIND_RD,
      S_FIND_CMP,
      S_UPDATE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SCAN,
      S_SCAN_LAST
   } state_type;

   // sequencer state
   state_type                  state_ff, state_in;
   logic [1:0]                 op_ff, op_in;
   logic [KEY_W-1:0]           key_ff, key_in;
   logic signed [VALUE_W-1:0]  val_ff, val_in;
   logic signed [VALUE_W-1:0]  lo_ff, lo_in;
   logic signed [VALUE_W-1:0]  hi_ff, hi_in;
   logic [BW-1:0]              bucket_ff, bucket_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [LEN_W-1:0]           pos_ff, pos_in;
   logic                       found_ff, found_in;
   logic signed [VALUE_W-1:0]  found_val_ff, found_val_in;
   logic [LEN_W-1:0]           chain_len_ff [BUCKETS];
   logic [LEN_W-1:0]           chain_len_in [BUCKETS];

   // scan walk and one-deep hold of the latest match
   logic [BW-1:0]              scan_bucket_ff, scan_bucket_in;
   logic [LEN_W-1:0]           scan_pos_ff, scan_pos_in;
   logic [ADDR_W-1:0]          scan_base_ff, scan_base_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic                       pend_valid_ff, pend_valid_in;
   entry_type                  pend_ff, pend_in;

   // registered outputs
   logic                       rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type               rsp_item_ff, rsp_item_in;

   // slot memory
   entry_type                  slot_mem [SLOTS];
   entry_type                  mem_rd_ff;
   logic [ADDR_W-1:0]          mem_rd_addr;
   logic                       mem_wr_en;
   logic [ADDR_W-1:0]          mem_wr_addr;
   entry_type                  mem_wr_data;

   // hash unit
   logic                       hash_start;
   logic                       hash_done;
   logic [KEY_W-1:0]           hash_key;
   logic [BW-1:0]              hash_bucket;

   logic                       accept;
   logic                       scan_hit;
   logic [LEN_W-1:0]           scan_len;
   logic [ADDR_W-1:0]          find_addr;

   assign accept     = start && (state_ff == S_IDLE);
   assign hash_start = accept && (req_item.opcode != OP_SCAN);
   assign busy       = (state_ff != S_IDLE);

   assign find_addr = base_ff + ADDR_W'(pos_ff);
   assign scan_len  = chain_len_ff[scan_bucket_ff];
   assign scan_hit  = rd_valid_ff && (mem_rd_ff.value >= lo_ff) &&
                      (mem_rd_ff.value <= hi_ff);

   chm_hash #(
      .BUCKETS   (BUCKETS),
      .KEY_CHARS (KEY_CHARS)
   ) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (hash_start),
      .raw_key    (req_item.item_key),
      .done       (hash_done),
      .key_out    (hash_key),
      .bucket_out (hash_bucket)
   );

   // slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slot_mem[mem_wr_addr] <= mem_wr_data;
      end
      mem_rd_ff <= slot_mem[mem_rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      bucket_in      = bucket_ff;
      base_in        = base_ff;
      len_in         = len_ff;
      pos_in         = pos_ff;
      found_in       = found_ff;
      found_val_in   = found_val_ff;
      chain_len_in   = chain_len_ff;
      scan_bucket_in = scan_bucket_ff;
      scan_pos_in    = scan_pos_ff;
      scan_base_in   = scan_base_ff;
      rd_valid_in    = 1'b0;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      rsp_strobe_in  = 1'b0;
      rsp_item_in    = rsp_item_ff;
      mem_rd_addr    = find_addr;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = find_addr;
      mem_wr_data    = '{key: key_ff, value: val_ff};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_item.opcode;
               val_in = req_item.item_value;
               lo_in = req_item.range_low;
               hi_in = req_item.range_high;
               if (req_item.opcode == OP_SCAN) begin
                  scan_bucket_in = '0;
                  scan_pos_in    = '0;
                  scan_base_in   = '0;
                  pend_valid_in  = 1'b0;
                  state_in       = S_SCAN;
               end else begin
                  state_in = S_HASH;
               end
            end
         end

         S_HASH: begin
            if (hash_done) begin
               key_in    = hash_key;
               bucket_in = hash_bucket;
               base_in   = ADDR_W'(hash_bucket * CHAIN_DEPTH);
               len_in    = chain_len_ff[hash_bucket];
               pos_in    = '0;
               found_in  = 1'b0;
               state_in  = S_FIND_RD;
            end
         end

         // walk the chain, one read then one compare per entry
         S_FIND_RD: begin
            if (pos_ff < len_ff) begin
               state_in = S_FIND_CMP;
            end else begin
               state_in = S_UPDATE;
            end
         end

         S_FIND_CMP: begin
            if (mem_rd_ff.key == key_ff) begin
               found_in     = 1'b1;
               found_val_in = mem_rd_ff.value;
               state_in     = S_UPDATE;
            end else begin
               pos_in   = pos_ff + LEN_W'(1);
               state_in = S_FIND_RD;
            end
         end

         S_UPDATE: begin
            rsp_item_in = '{status: ST_NOT_FOUND, found_key: '0, found_value: '0,
                            last_result: 1'b1};
            state_in    = S_IDLE;
            case (op_ff)
               OP_INSERT: begin
                  rsp_strobe_in = 1'b1;
                  if (found_ff) begin
                     // key present: overwrite its value in place
                     mem_wr_en   = 1'b1;
                     rsp_item_in = '{status: ST_UPDATED, found_key: key_ff,
                                     found_value: val_ff, last_result: 1'b1};
                  end else if (len_ff >= LEN_W'(CHAIN_DEPTH)) begin
                     rsp_item_in.status = ST_CHAIN_FULL;
                  end else begin
                     // append at the tail of the chain
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = base_ff + ADDR_W'(len_ff);
                     chain_len_in[bucket_ff] = len_ff + LEN_W'(1);
                     rsp_item_in = '{status: ST_ADDED, found_key: key_ff,
                                     found_value: val_ff, last_result: 1'b1};
                  end
               end
               OP_LOOKUP: begin
                  rsp_strobe_in = 1'b1;
                  if (found_ff) begin
                     rsp_item_in = '{status: ST_FOUND, found_key: key_ff,
                                     found_value: found_val_ff, last_result: 1'b1};
                  end
               end
               OP_REMOVE: begin
                  if (found_ff) begin
                     state_in = S_SHIFT_RD;
                  end else begin
                     rsp_strobe_in = 1'b1;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // move later entries up one place, keeping order
         S_SHIFT_RD: begin
            mem_rd_addr = find_addr + ADDR_W'(1);
            if ((pos_ff + LEN_W'(1)) < len_ff) begin
               state_in = S_SHIFT_WR;
            end else begin
               chain_len_in[bucket_ff] = len_ff - LEN_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{status: ST_REMOVED, found_key: key_ff,
                                 found_value: found_val_ff, last_result: 1'b1};
               state_in      = S_IDLE;
            end
         end

         S_SHIFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_ff;
            pos_in      = pos_ff + LEN_W'(1);
            state_in    = S_SHIFT_RD;
         end

         S_SCAN: begin
            // compare the slot read last cycle; a new match releases the held one
            if (scan_hit) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_item_in   = '{status: ST_FOUND, found_key: pend_ff.key,
                                    found_value: pend_ff.value, last_result: 1'b0};
               end
               pend_valid_in = 1'b1;
               pend_in       = mem_rd_ff;
            end
            // issue the next slot read, step to the next bucket, or close after the last one
            mem_rd_addr = scan_base_ff + ADDR_W'(scan_pos_ff);
            if (scan_pos_ff < scan_len) begin
               rd_valid_in = 1'b1;
               scan_pos_in = scan_pos_ff + LEN_W'(1);
            end else if (scan_bucket_ff == BW'(BUCKETS - 1)) begin
               state_in = S_SCAN_LAST;
            end else begin
               scan_bucket_in = scan_bucket_ff + BW'(1);
               scan_pos_in    = '0;
               scan_base_in   = scan_base_ff + ADDR_W'(CHAIN_DEPTH);
            end
         end

         S_SCAN_LAST: begin
            rsp_strobe_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_item_in = '{status: ST_FOUND, found_key: pend_ff.key,
                               found_value: pend_ff.value, last_result: 1'b1};
            end else begin
               rsp_item_in = '{status: ST_NOT_FOUND, found_key: '0, found_value: '0,
                               last_result: 1'b1};
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         for (int i = 0; i < BUCKETS; i++) begin
            chain_len_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         chain_len_ff  <= chain_len_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      bucket_ff      <= bucket_in;
      base_ff        <= base_in;
      len_ff         <= len_in;
      pos_ff         <= pos_in;
      found_val_ff   <= found_val_in;
      scan_bucket_ff <= scan_bucket_in;
      scan_pos_ff    <= scan_pos_in;
      scan_base_ff   <= scan_base_in;
      pend_ff        <= pend_in;
      rsp_item_ff    <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire
